FILE: design/largest_empty_square_finder_top_assert.svh
// Assertion macros used by the top design file.
`ifndef LARGEST_EMPTY_SQUARE_FINDER_TOP_ASSERT_SVH
`define LARGEST_EMPTY_SQUARE_FINDER_TOP_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define LESF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define LESF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/lesf_pkg.sv
package lesf_pkg;

  // Map limits.
  localparam int unsigned MAX_COLS = 1024;
  localparam int unsigned MAX_ROWS = 1024;

  // Field widths.
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned COL_W    = $clog2(MAX_COLS);
  localparam int unsigned ROW_W    = $clog2(MAX_ROWS);
  localparam int unsigned ROWCNT_W = $clog2(MAX_ROWS + 1);
  localparam int unsigned SIZE_W   = 11;
  localparam int unsigned CFG_W    = 11;

  typedef logic [CHAR_W-1:0] char_t;
  typedef logic [COL_W-1:0]  col_t;
  typedef logic [ROW_W-1:0]  row_t;
  typedef logic [SIZE_W-1:0] size_t;
  typedef logic [CFG_W-1:0]  cfg_data_t;
  typedef logic [1:0]        cfg_idx_t;

  // Register indexes of the configuration port.
  localparam cfg_idx_t CFG_EMPTY_CHAR    = 2'd0;
  localparam cfg_idx_t CFG_OBSTACLE_CHAR = 2'd1;
  localparam cfg_idx_t CFG_ROW_WIDTH     = 2'd2;

  // Reset values of the registers.
  localparam char_t     EMPTY_CHAR_RST    = 8'd46;
  localparam char_t     OBSTACLE_CHAR_RST = 8'd111;
  localparam cfg_data_t ROW_WIDTH_RST     = 11'd16;

  // Row width as used: zero counts as one, large values saturate at the line length.
  function automatic size_t eff_width(input cfg_data_t w);
    size_t r;
    r = w;
    if (w == '0) begin
      r = size_t'(1);
    end else if (w > cfg_data_t'(MAX_COLS)) begin
      r = size_t'(MAX_COLS);
    end
    return r;
  endfunction

  // A column at or past the width is pulled back to the last column.
  function automatic col_t clamp_col(input col_t c, input size_t w);
    col_t r;
    r = c;
    if (size_t'(c) >= w) begin
      r = col_t'(w - size_t'(1));
    end
    return r;
  endfunction

  function automatic size_t min3(input size_t p, input size_t q, input size_t r);
    size_t m;
    m = (p < q) ? p : q;
    return (m < r) ? m : r;
  endfunction

endpackage

FILE: design/lesf_ram.sv
module lesf_ram #(
  parameter int unsigned Width = 11,
  parameter int unsigned Depth = 1024,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [Width-1:0] wr_data_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  // Single write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read, old data on a same-address write.
  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: design/largest_empty_square_finder_top.sv
// Largest empty square finder.
// Input channel: one map cell a word (cell_byte_i, last_cell_i), raster order
// without newlines, taken when in_valid_i is high and in_stall_o is low.
// Output channel: one result word (size, bottom-right row and column, error)
// for each cell marked last, taken when out_valid_o is high and out_stall_i low.
// Configuration: cfg_valid_i/cfg_ready_o with cfg_index_i (0 empty character,
// 1 obstacle character, 2 row width) and cfg_data_i; cfg_ready_o is always high.
// Throughput is one cell a cycle while in_stall_o is low: the line buffer is read
// ahead at the next column, with a forwarding register when that column was just written.
// Latency: the result word is valid the cycle after its last cell is accepted,
// unless an earlier word is still waiting, in which case it queues behind it.
// The input is stalled in the cycle after each configuration write, while the
// line buffer read is refetched, and while two result words wait on a stalled
// receiver; a single waiting word does not hold up the cells. Reset restores
// the register defaults and clears counters, the best square and the error
// flag; the line buffer needs no clearing pass, since a row reads only entries
// written by the row above it.
module largest_empty_square_finder_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  lesf_pkg::cfg_idx_t   cfg_index_i,
  input  lesf_pkg::cfg_data_t  cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  lesf_pkg::char_t      cell_byte_i,
  input  logic                 last_cell_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output lesf_pkg::size_t      square_size_o,
  output lesf_pkg::row_t       square_row_o,
  output lesf_pkg::col_t       square_col_o,
  output logic                 map_error_o
);

  import lesf_pkg::*;

  `include "largest_empty_square_finder_top_assert.svh"

  char_t     empty_char_q, obstacle_char_q;
  cfg_data_t row_width_q;
  logic      settle_q;

  col_t                col_q, col_d;
  logic [ROWCNT_W-1:0] row_q, row_d;
  size_t               left_q, left_d, diag_q, diag_d;
  size_t               best_size_q, best_size_d;
  row_t                best_row_q, best_row_d;
  col_t                best_col_q, best_col_d;
  logic                err_q, err_d;

  logic  out_valid_q;
  size_t out_size_q;
  row_t  out_row_q;
  col_t  out_col_q;
  logic  out_err_q;

  logic  skid_valid_q;
  size_t skid_size_q;
  row_t  skid_row_q;
  col_t  skid_col_q;
  logic  skid_err_q;

  logic  byp_q;
  size_t byp_data_q;

  logic  in_acc, cfg_acc, push, pop;
  size_t width_eff;
  col_t  col_eff;
  size_t ram_rd, up_raw, up, left, diag, s;
  logic  in_map, is_empty, is_obst, last_col;
  logic  wr_en;
  col_t  rd_addr;

  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;
  assign in_stall_o  = settle_q || skid_valid_q;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign push        = in_acc && last_cell_i;
  assign pop         = out_valid_q && !out_stall_i;

  // Configuration registers; a write also sets settle_q, which stalls the input.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      empty_char_q    <= EMPTY_CHAR_RST;
      obstacle_char_q <= OBSTACLE_CHAR_RST;
      row_width_q     <= ROW_WIDTH_RST;
      settle_q        <= 1'b0;
    end else begin
      settle_q <= cfg_acc;
      if (cfg_acc) begin
        case (cfg_index_i)
          CFG_EMPTY_CHAR:    empty_char_q    <= cfg_data_i[CHAR_W-1:0];
          CFG_OBSTACLE_CHAR: obstacle_char_q <= cfg_data_i[CHAR_W-1:0];
          CFG_ROW_WIDTH:     row_width_q     <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Neighbour sizes of the current cell.
  assign width_eff = eff_width(row_width_q);
  assign col_eff   = clamp_col(col_q, width_eff);
  assign up_raw    = byp_q ? byp_data_q : ram_rd;
  assign up        = (row_q != '0) ? up_raw : '0;
  assign left      = (col_eff != '0) ? left_q : '0;
  assign diag      = ((row_q != '0) && (col_eff != '0)) ? diag_q : '0;
  assign in_map    = row_q < ROWCNT_W'(MAX_ROWS);
  assign is_empty  = cell_byte_i == empty_char_q;
  assign is_obst   = cell_byte_i == obstacle_char_q;
  assign s         = is_empty ? (min3(up, left, diag) + size_t'(1)) : '0;
  assign last_col  = (size_t'(col_eff) + size_t'(1)) >= width_eff;
  assign wr_en     = in_acc && in_map;

  // Next state of the scan.
  always_comb begin
    col_d       = col_q;
    row_d       = row_q;
    left_d      = left_q;
    diag_d      = diag_q;
    best_size_d = best_size_q;
    best_row_d  = best_row_q;
    best_col_d  = best_col_q;
    err_d       = err_q;
    if (in_acc) begin
      if ((empty_char_q == obstacle_char_q) || (!is_empty && !is_obst)) begin
        err_d = 1'b1;
      end
      if (in_map) begin
        if (is_empty && (s > best_size_q)) begin
          best_size_d = s;
          best_row_d  = row_t'(row_q);
          best_col_d  = col_eff;
        end
        if (last_col) begin
          col_d  = '0;
          left_d = '0;
          diag_d = '0;
          row_d  = row_q + ROWCNT_W'(1);
        end else begin
          col_d  = col_eff + col_t'(1);
          left_d = s;
          diag_d = up;
        end
      end else begin
        col_d = col_eff;
      end
    end
  end

  // Scan state; an accepted last cell of a map clears it as its result is stored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      left_q      <= '0;
      diag_q      <= '0;
      best_size_q <= '0;
      best_row_q  <= '0;
      best_col_q  <= '0;
      err_q       <= 1'b0;
    end else if (in_acc && last_cell_i) begin
      col_q       <= '0;
      row_q       <= '0;
      left_q      <= '0;
      diag_q      <= '0;
      best_size_q <= '0;
      best_row_q  <= '0;
      best_col_q  <= '0;
      err_q       <= 1'b0;
    end else begin
      col_q       <= col_d;
      row_q       <= row_d;
      left_q      <= left_d;
      diag_q      <= diag_d;
      best_size_q <= best_size_d;
      best_row_q  <= best_row_d;
      best_col_q  <= best_col_d;
      err_q       <= err_d;
    end
  end

  // Line buffer of the row above, read ahead at the address of the next column.
  assign rd_addr = clamp_col(col_d, width_eff);

  lesf_ram #(
    .Width (SIZE_W),
    .Depth (MAX_COLS)
  ) u_line_buf (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (col_eff),
    .wr_data_i (s),
    .rd_addr_i (rd_addr),
    .rd_data_o (ram_rd)
  );

  // Forward a size written to the column that is read in the same cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q      <= 1'b0;
      byp_data_q <= '0;
    end else begin
      byp_q      <= wr_en && (col_eff == rd_addr);
      byp_data_q <= s;
    end
  end

  // Result register with a skid slot behind it, so that one waiting word
  // does not hold up the cells.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (pop) begin
      out_valid_q  <= skid_valid_q || push;
      skid_valid_q <= 1'b0;
    end else if (push) begin
      out_valid_q  <= 1'b1;
      skid_valid_q <= out_valid_q;
    end
  end

  // The result register takes the skid word first, else a fresh word.
  always_ff @(posedge clk_i) begin
    if (pop && skid_valid_q) begin
      out_size_q <= skid_size_q;
      out_row_q  <= skid_row_q;
      out_col_q  <= skid_col_q;
      out_err_q  <= skid_err_q;
    end else if (push && (!out_valid_q || pop)) begin
      out_size_q <= best_size_d;
      out_row_q  <= best_row_d;
      out_col_q  <= best_col_d;
      out_err_q  <= err_d;
    end
  end

  // The skid slot catches a fresh word while the result register is stalled.
  always_ff @(posedge clk_i) begin
    if (push && out_valid_q && !pop) begin
      skid_size_q <= best_size_d;
      skid_row_q  <= best_row_d;
      skid_col_q  <= best_col_d;
      skid_err_q  <= err_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign square_size_o = out_size_q;
  assign square_row_o  = out_row_q;
  assign square_col_o  = out_col_q;
  assign map_error_o   = out_err_q;

  // Checks on the scan and the result register.
  `LESF_ASSERT_NOW(a_skid_order, skid_valid_q, out_valid_q, "skid word without result word")
  `LESF_ASSERT_NEXT(a_result_follows, in_acc && last_cell_i, out_valid_q, "result missing")
  `LESF_ASSERT_NOW(a_row_bound, 1'b1, row_q <= ROWCNT_W'(MAX_ROWS), "row count past limit")
  `LESF_ASSERT_NOW(a_empty_corner, out_valid_q && (out_size_q == '0),
                   (out_row_q == '0) && (out_col_q == '0), "corner set without square")
  `LESF_ASSERT_NEXT(a_cfg_settle, cfg_acc, in_stall_o, "input taken during refetch")

endmodule

FILE: bench/tb_largest_empty_square_finder_top.sv
`timescale 1ns / 100ps

module tb_largest_empty_square_finder_top;
  import lesf_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned MAX_REPORTS   = 10;
  localparam int unsigned RANDOM_CELLS  = 370;

  localparam char_t DOT = EMPTY_CHAR_RST;
  localparam char_t OBS = OBSTACLE_CHAR_RST;

  // One result word as the block reports it.
  typedef struct packed {
    size_t size;
    row_t  row;
    col_t  col;
    logic  err;
  } square_t;

  // A directed step is either a register write or one cell word. Typed rows
  // carry their expected square; the others are left to the predictor.
  typedef struct packed {
    logic      is_write;
    cfg_idx_t  idx;
    cfg_data_t data;
    char_t     cell_chr;
    logic      last;
    logic      typed;
    square_t   res;
  } plan_row_t;

  localparam logic    CELL_ROW  = 1'b0;
  localparam logic    WRITE_ROW = 1'b1;
  localparam logic    TYPED     = 1'b1;
  localparam logic    PREDICTED = 1'b0;
  localparam square_t NO_SQ     = '0;

  localparam plan_row_t DIRECTED_PLAN [32] = '{
    // Short maps after reset: empty, obstacle, bad byte, bad then empty.
    '{CELL_ROW,  CFG_EMPTY_CHAR,    11'd0,   DOT,   1'b1, TYPED,     '{11'd1, 10'd0, 10'd0, 1'b0}},
    '{CELL_ROW,  CFG_EMPTY_CHAR,    11'd0,   OBS,   1'b1, TYPED,     '{11'd0, 10'd0, 10'd0, 1'b0}},
    '{CELL_ROW,  CFG_EMPTY_CHAR,    11'd0,   8'hFF, 1'b1, TYPED,     '{11'd0, 10'd0, 10'd0, 1'b1}},
    '{CELL_ROW,  CFG_EMPTY_CHAR,    11'd0,   8'h00, 1'b0, PREDICTED, NO_SQ},
    '{CELL_ROW,  CFG_EMPTY_CHAR,    11'd0,   DOT,   1'b1, TYPED,     '{11'd1, 10'd0, 10'd1, 1'b1}},
    // A full two-by-two square.
    '{WRITE_ROW, CFG_ROW_WIDTH,     11'd2,   8'h00, 1'b0, PREDICTED, NO_SQ},
    '{CELL_ROW,  CFG_EMPTY_CHAR,    11'd0,   DOT,   1'b0, PREDICTED, NO_SQ},
    '{CELL_ROW,  CFG_EMPTY_CHAR,    11'd0,   DOT,   1'b0, PREDICTED, NO_SQ},
    '{CELL_ROW,  CFG_EMPTY_CHAR,    11'd0,   DOT,   1'b0, PREDICTED, NO_SQ},
    '{CELL_ROW,  CFG_EMPTY_CHAR,    11'd0,   DOT,   1'b1, TYPED,     '{11'd2, 10'd1, 10'd1, 1'b0}},
    // Equal empty and obstacle characters.
    '{WRITE_ROW, CFG_OBSTACLE_CHAR, 11'd46,  8'h00, 1'b0, PREDICTED, NO_SQ},
    '{CELL_ROW,  CFG_EMPTY_CHAR,    11'd0,   DOT,   1'b1, TYPED,     '{11'd1, 10'd0, 10'd0, 1'b1}},
    '{WRITE_ROW, CFG_OBSTACLE_CHAR, 11'd111, 8'h00, 1'b0, PREDICTED, NO_SQ},
    // Row width zero behaves as a single column.
    '{WRITE_ROW, CFG_ROW_WIDTH,     11'd0,   8'h00, 1'b0, PREDICTED, NO_SQ},
    '{CELL_ROW,  CFG_EMPTY_CHAR,    11'd0,   DOT,   1'b0, PREDICTED, NO_SQ},
    '{CELL_ROW,  CFG_EMPTY_CHAR,    11'd0,   DOT,   1'b0, PREDICTED, NO_SQ},
    '{CELL_ROW,  CFG_EMPTY_CHAR,    11'd0,   DOT,   1'b1, TYPED,     '{11'd1, 10'd0, 10'd0, 1'b0}},
    // Width shrunk mid-map while the column count is already past it.
    '{WRITE_ROW, CFG_ROW_WIDTH,     11'd4,   8'h00, 1'b0, PREDICTED, NO_SQ},
    '{CELL_ROW,  CFG_EMPTY_CHAR,    11'd0,   DOT,   1'b0, PREDICTED, NO_SQ},
    '{CELL_ROW,  CFG_EMPTY_CHAR,    11'd0,   DOT,   1'b0, PREDICTED, NO_SQ},
    '{CELL_ROW,  CFG_EMPTY_CHAR,    11'd0,   DOT,   1'b0, PREDICTED, NO_SQ},
    '{WRITE_ROW, CFG_ROW_WIDTH,     11'd2,   8'h00, 1'b0, PREDICTED, NO_SQ},
    '{CELL_ROW,  CFG_EMPTY_CHAR,    11'd0,   DOT,   1'b0, PREDICTED, NO_SQ},
    '{CELL_ROW,  CFG_EMPTY_CHAR,    11'd0,   DOT,   1'b0, PREDICTED, NO_SQ},
    '{CELL_ROW,  CFG_EMPTY_CHAR,    11'd0,   DOT,   1'b1, PREDICTED, NO_SQ},
    // Extreme character codes, with spare upper data bits on the write.
    '{WRITE_ROW, CFG_EMPTY_CHAR,    11'h700, 8'h00, 1'b0, PREDICTED, NO_SQ},
    '{WRITE_ROW, CFG_OBSTACLE_CHAR, 11'h0FF, 8'h00, 1'b0, PREDICTED, NO_SQ},
    '{WRITE_ROW, CFG_ROW_WIDTH,     11'd3,   8'h00, 1'b0, PREDICTED, NO_SQ},
    '{CELL_ROW,  CFG_EMPTY_CHAR,    11'd0,   8'h00, 1'b0, PREDICTED, NO_SQ},
    '{CELL_ROW,  CFG_EMPTY_CHAR,    11'd0,   8'hFF, 1'b0, PREDICTED, NO_SQ},
    '{CELL_ROW,  CFG_EMPTY_CHAR,    11'd0,   8'h80, 1'b0, PREDICTED, NO_SQ},
    '{CELL_ROW,  CFG_EMPTY_CHAR,    11'd0,   8'h00, 1'b1, TYPED,     '{11'd1, 10'd0, 10'd0, 1'b1}}
  };

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      cfg_valid_i = 1'b0;
  logic      cfg_ready_o;
  cfg_idx_t  cfg_index_i = CFG_EMPTY_CHAR;
  cfg_data_t cfg_data_i  = '0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  char_t     cell_byte_i = '0;
  logic      last_cell_i = 1'b0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  size_t     square_size_o;
  row_t      square_row_o;
  col_t      square_col_o;
  logic      map_error_o;

  // Shadow registers and map state of the predictor.
  char_t       empty_chr = EMPTY_CHAR_RST;
  char_t       obst_chr  = OBSTACLE_CHAR_RST;
  cfg_data_t   width_cfg = ROW_WIDTH_RST;
  int unsigned line_sizes [MAX_COLS];
  int unsigned left_sz   = 0;
  int unsigned diag_sz   = 0;
  int unsigned col_pos   = 0;
  int unsigned row_pos   = 0;
  int unsigned best_sz   = 0;
  int unsigned best_r    = 0;
  int unsigned best_c    = 0;
  logic        bad_char_seen = 1'b0;

  square_t     pending_squares [$];
  int unsigned bad_squares  = 0;
  int unsigned cycle_cnt    = 0;

  // Idling controls: quiet switches all idling off, gaps_on the sender's.
  bit          quiet   = 1'b0;
  bit          gaps_on = 1'b1;
  int unsigned stall_left = 0;
  int unsigned calm_left  = 0;

  largest_empty_square_finder_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .cell_byte_i   (cell_byte_i),
    .last_cell_i   (last_cell_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .square_size_o (square_size_o),
    .square_row_o  (square_row_o),
    .square_col_o  (square_col_o),
    .map_error_o   (map_error_o)
  );

  always #4 clk_i = ~clk_i;

  // Advance the square map by one accepted cell and report the square
  // found when the cell closes the map.
  function automatic void scan_cell(input char_t cell_chr, input logic last,
                                    output bit emits, output square_t sq);
    int unsigned w;
    int unsigned col;
    int unsigned up;
    int unsigned left;
    int unsigned diag;
    int unsigned s;
    w = width_cfg;
    if (w == 0) begin
      w = 1;
    end else if (w > MAX_COLS) begin
      w = MAX_COLS;
    end
    if (col_pos >= w) begin
      col_pos = w - 1;
    end
    if (empty_chr == obst_chr) begin
      bad_char_seen = 1'b1;
    end
    if (row_pos < MAX_ROWS) begin
      col  = col_pos;
      up   = (row_pos > 0) ? line_sizes[col] : 0;
      left = (col > 0) ? left_sz : 0;
      diag = (row_pos > 0 && col > 0) ? diag_sz : 0;
      s    = 0;
      if (cell_chr == empty_chr) begin
        s = (up < left) ? up : left;
        if (diag < s) begin
          s = diag;
        end
        s = s + 1;
        // Only a strictly larger square replaces the one already held.
        if (s > best_sz) begin
          best_sz = s;
          best_r  = row_pos;
          best_c  = col;
        end
      end else if (cell_chr != obst_chr) begin
        bad_char_seen = 1'b1;
      end
      diag_sz = up;
      left_sz = s;
      line_sizes[col] = s;
      if (col + 1 >= w) begin
        col_pos = 0;
        left_sz = 0;
        diag_sz = 0;
        row_pos++;
      end else begin
        col_pos = col + 1;
      end
    end else if (cell_chr != empty_chr && cell_chr != obst_chr) begin
      // Past the last row a cell is ignored apart from its validity.
      bad_char_seen = 1'b1;
    end
    emits = last;
    sq    = '0;
    if (last) begin
      sq.size = size_t'(best_sz);
      sq.row  = row_t'(best_r);
      sq.col  = col_t'(best_c);
      sq.err  = bad_char_seen;
      left_sz = 0;
      diag_sz = 0;
      col_pos = 0;
      row_pos = 0;
      best_sz = 0;
      best_r  = 0;
      best_c  = 0;
      bad_char_seen = 1'b0;
    end
  endfunction

  // Drop the input valid, wait for every outstanding square and let the
  // block finish any cell still in flight.
  task automatic settle();
    @(negedge clk_i) in_valid_i <= 1'b0;
    while (pending_squares.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write one configuration register once the block is idle.
  task automatic write_reg(input cfg_idx_t idx, input cfg_data_t data);
    settle();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_EMPTY_CHAR: begin
        empty_chr = data[CHAR_W-1:0];
      end
      CFG_OBSTACLE_CHAR: begin
        obst_chr = data[CHAR_W-1:0];
      end
      CFG_ROW_WIDTH: begin
        width_cfg = data;
      end
      default: begin
      end
    endcase
    @(negedge clk_i) cfg_valid_i <= 1'b0;
  endtask

  // Offer one cell word, possibly after a random gap, and record the square
  // it should produce once the block has taken it.
  task automatic send_cell(input char_t cell_chr, input logic last, input logic typed,
                           input square_t typed_sq);
    square_t predicted;
    bit      emits;
    int unsigned gap;
    if (!quiet && gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      repeat (gap) @(negedge clk_i) in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i  <= 1'b1;
    cell_byte_i <= cell_chr;
    last_cell_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    scan_cell(cell_chr, last, emits, predicted);
    if (emits) begin
      pending_squares.push_back(typed ? typed_sq : predicted);
    end
  endtask

  // Receiver stalls come in bursts of random length, with calm stretches.
  always @(negedge clk_i) begin
    if (quiet) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else if (calm_left > 0) begin
      out_stall_i <= 1'b0;
      calm_left--;
    end else begin
      out_stall_i <= 1'b0;
      if ($urandom_range(0, 39) == 0) begin
        calm_left = $urandom_range(50, 200);
      end else if ($urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 7);
      end
    end
  end

  // Compare each accepted result word with the oldest expected square.
  always @(posedge clk_i) begin : check_squares
    square_t got;
    square_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{square_size_o, square_row_o, square_col_o, map_error_o};
      if (pending_squares.size() == 0) begin
        bad_squares++;
        if (bad_squares <= MAX_REPORTS) begin
          $display("unexpected square: size %0d row %0d col %0d error %0b",
                   got.size, got.row, got.col, got.err);
        end
      end else begin
        want = pending_squares.pop_front();
        if (got !== want) begin
          bad_squares++;
          if (bad_squares <= MAX_REPORTS) begin
            $display({"square mismatch: expected size %0d row %0d col %0d error %0b,",
                      " got size %0d row %0d col %0d error %0b"},
                     want.size, want.row, want.col, want.err,
                     got.size, got.row, got.col, got.err);
          end
        end
      end
    end
  end

  // Give up if the run hangs.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb_largest_empty_square_finder_top failed");
      $finish;
    end
  end

  initial begin
    plan_row_t   step;
    int unsigned rand_cells;
    int unsigned n_cells;
    int unsigned eff_w;
    int unsigned pick;
    char_t       map_chr;
    char_t       e_code;
    char_t       o_code;
    cfg_data_t   w_code;

    rand_cells = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // Directed steps.
    foreach (DIRECTED_PLAN[i]) begin
      step = DIRECTED_PLAN[i];
      if (step.is_write) begin
        write_reg(step.idx, step.data);
      end else begin
        send_cell(step.cell_chr, step.last, step.typed, step.res);
      end
    end
    write_reg(CFG_EMPTY_CHAR, cfg_data_t'(DOT));
    write_reg(CFG_OBSTACLE_CHAR, cfg_data_t'(OBS));

    // An oversized width saturates at the line length; a short map stays
    // on the first row.
    write_reg(CFG_ROW_WIDTH, 11'd2047);
    send_cell(DOT, 1'b0, PREDICTED, NO_SQ);
    send_cell(DOT, 1'b0, PREDICTED, NO_SQ);
    send_cell(OBS, 1'b0, PREDICTED, NO_SQ);
    send_cell(DOT, 1'b0, PREDICTED, NO_SQ);
    send_cell(DOT, 1'b1, PREDICTED, NO_SQ);

    // Random maps: mostly empty cells so that squares grow, some obstacles
    // and stray bytes, now and then cut short.
    while (rand_cells < RANDOM_CELLS) begin
      if ($urandom_range(0, 2) == 0) begin
        e_code = char_t'($urandom_range(0, 255));
        o_code = ($urandom_range(0, 9) == 0) ? e_code : char_t'($urandom_range(0, 255));
        pick = $urandom_range(0, 11);
        case (pick)
          0:       w_code = '0;
          1:       w_code = cfg_data_t'(MAX_COLS);
          2:       w_code = 11'd2047;
          default: w_code = cfg_data_t'($urandom_range(1, 8));
        endcase
        write_reg(CFG_EMPTY_CHAR, {3'($urandom_range(0, 7)), e_code});
        write_reg(CFG_OBSTACLE_CHAR, {3'($urandom_range(0, 7)), o_code});
        write_reg(CFG_ROW_WIDTH, w_code);
      end else if ($urandom_range(0, 7) == 0) begin
        settle();
      end
      gaps_on = ($urandom_range(0, 3) != 0);
      quiet   = (rand_cells + 60 >= RANDOM_CELLS);
      eff_w = width_cfg;
      if (eff_w == 0) begin
        eff_w = 1;
      end else if (eff_w > MAX_COLS) begin
        eff_w = MAX_COLS;
      end
      if (eff_w > 8) begin
        n_cells = $urandom_range(1, 40);
      end else begin
        n_cells = $urandom_range(1, 6) * eff_w;
        if ($urandom_range(0, 3) == 0) begin
          n_cells = $urandom_range(1, n_cells);
        end
      end
      for (int k = 0; k < n_cells; k++) begin
        pick = $urandom_range(0, 19);
        if (pick < 15) begin
          map_chr = empty_chr;
        end else if (pick < 18) begin
          map_chr = obst_chr;
        end else begin
          map_chr = char_t'($urandom_range(0, 255));
        end
        send_cell(map_chr, k == n_cells - 1, PREDICTED, NO_SQ);
        rand_cells++;
      end
    end

    settle();
    if (bad_squares == 0) begin
      $display("tb_largest_empty_square_finder_top passed");
    end else begin
      $display("tb_largest_empty_square_finder_top failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+design
design/lesf_pkg.sv
design/lesf_ram.sv
design/largest_empty_square_finder_top.sv
bench/tb_largest_empty_square_finder_top.sv
